FILE: hw/rtl/skmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skmm_pkg
// Shared types and constants of the sorted key match and mark block.
// ----------------------------------------------------------------------------
package skmm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_CHARS_DEF   = 7;

  // fixed field widths of the stream payloads
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_IN_W = 56;
  localparam int unsigned IDX_IN_W = 10;
  localparam int unsigned MCOUNT_W = 11;
  localparam int unsigned REPL_W   = 56;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_RANGE   = 2'd2,
    STS_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e                     status;
    logic [MCOUNT_W-1:0]         match_count;
    logic [REPL_W-1:0]           replacement;
    logic                        replacement_valid;
  } result_t;

endpackage

FILE: hw/rtl/skmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skmm_ram
// Simple dual-port synchronous memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module skmm_ram #(
  parameter int unsigned DEPTH = skmm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = 8 * skmm_pkg::KEY_CHARS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/skmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skmm_ctrl
// Command sequencer: loads keys, runs the binary search and the marking scan
// over the key memory, reads marks, and builds one result per transaction.
// ----------------------------------------------------------------------------
module skmm_ctrl #(
  parameter int unsigned TABLE_DEPTH = skmm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_CHARS   = skmm_pkg::KEY_CHARS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [skmm_pkg::CMD_W-1:0]          cmd_i,
  input  logic [skmm_pkg::KEY_IN_W-1:0]       key_i,
  input  logic [skmm_pkg::KEY_IN_W-1:0]       new_key_i,
  input  logic [skmm_pkg::IDX_IN_W-1:0]       idx_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output skmm_pkg::result_t                   res_o,
  output logic                                key_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      key_waddr_o,
  output logic [8*KEY_CHARS-1:0]              key_wdata_o,
  output logic                                key_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      key_raddr_o,
  input  logic [8*KEY_CHARS-1:0]              key_rdata_i,
  output logic                                mark_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mark_waddr_o,
  output logic [8*KEY_CHARS:0]                mark_wdata_o,
  output logic                                mark_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mark_raddr_o,
  input  logic [8*KEY_CHARS:0]                mark_rdata_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KW    = 8 * KEY_CHARS;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW    = CNT_W + 1;
  localparam int unsigned CW    = (CNT_W > skmm_pkg::IDX_IN_W) ? CNT_W : skmm_pkg::IDX_IN_W;
  localparam int unsigned MW    = (CNT_W > skmm_pkg::MCOUNT_W) ? CNT_W : skmm_pkg::MCOUNT_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  // largest power of two not above the depth
  localparam logic [PW-1:0]    TOP_STEP  = PW'(1) << (CNT_W - 1);
  localparam logic [PW-1:0]    ONE_STEP  = PW'(1);

  skmm_pkg::state_e  state_q, state_d;
  logic [KW-1:0]     old_key_q, old_key_d;
  logic [KW-1:0]     new_key_q, new_key_d;
  logic [PW-1:0]     step_q, step_d;
  logic [PW-1:0]     loc_q, loc_d;
  logic [PW-1:0]     probe_q, probe_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  found_q, found_d;
  logic [CNT_W-1:0]  count_q, count_d;
  skmm_pkg::result_t res_q, res_d;

  logic [63:0]       key_ext, new_ext, repl_ext;
  logic [KW-1:0]     key_in, new_in;
  logic [CW-1:0]     idx_ext;
  logic              idx_in_range;
  logic [PW-1:0]     count_ext;
  logic              key_lt, key_gt, key_eq;
  logic [PW-1:0]     search_loc;
  logic [PW-1:0]     next_probe;
  logic [MW-1:0]     found_ext;

  assign key_ext      = 64'(key_i);
  assign new_ext      = 64'(new_key_i);
  assign key_in       = key_ext[KW-1:0];
  assign new_in       = new_ext[KW-1:0];
  assign idx_ext      = CW'(idx_i);
  assign idx_in_range = idx_ext < CW'(count_q);
  assign count_ext    = PW'(count_q);
  assign repl_ext     = 64'(mark_rdata_i[KW-1:0]);
  assign found_ext    = MW'(found_q);

  assign key_lt = key_rdata_i < old_key_q;
  assign key_gt = key_rdata_i > old_key_q;
  assign key_eq = key_rdata_i == old_key_q;

  // location after folding in the probe whose key has just come back
  assign search_loc = (pend_q && key_lt) ? probe_q : loc_q;

  assign in_ready_o  = state_q == skmm_pkg::S_IDLE;
  assign res_valid_o = state_q == skmm_pkg::S_RESP;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skmm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          priority case (cmd_i)
            skmm_pkg::CMD_QUERY: state_d = skmm_pkg::S_SEARCH;
            skmm_pkg::CMD_READ:  state_d = idx_in_range ? skmm_pkg::S_READ : skmm_pkg::S_RESP;
            default:             state_d = skmm_pkg::S_RESP;
          endcase
        end
      end
      skmm_pkg::S_SEARCH: begin
        if (step_q == ONE_STEP) begin
          state_d = skmm_pkg::S_SCAN;
        end
      end
      skmm_pkg::S_SCAN: begin
        if (!pend_q || key_gt) begin
          state_d = skmm_pkg::S_RESP;
        end
      end
      skmm_pkg::S_READ: state_d = skmm_pkg::S_RESP;
      skmm_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = skmm_pkg::S_IDLE;
        end
      end
      default: state_d = skmm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    old_key_d    = old_key_q;
    new_key_d    = new_key_q;
    step_d       = step_q;
    loc_d        = loc_q;
    probe_d      = probe_q;
    pend_d       = pend_q;
    found_d      = found_q;
    count_d      = count_q;
    res_d        = res_q;
    key_we_o     = 1'b0;
    key_waddr_o  = count_q[IDX_W-1:0];
    key_wdata_o  = key_in;
    key_re_o     = 1'b0;
    key_raddr_o  = '0;
    mark_we_o    = 1'b0;
    mark_waddr_o = count_q[IDX_W-1:0];
    mark_wdata_o = '0;
    mark_re_o    = 1'b0;
    mark_raddr_o = idx_ext[IDX_W-1:0];
    next_probe   = search_loc + (step_q >> 1);

    unique case (state_q)
      skmm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_d.status            = skmm_pkg::STS_OK;
          res_d.match_count       = '0;
          res_d.replacement       = '0;
          res_d.replacement_valid = 1'b0;
          priority case (cmd_i)
            skmm_pkg::CMD_LOAD: begin
              if (count_q == DEPTH_CNT) begin
                res_d.status = skmm_pkg::STS_FULL;
              end else begin
                // the entry's mark is cleared as its key is loaded
                key_we_o  = 1'b1;
                mark_we_o = 1'b1;
                count_d   = count_q + CNT_W'(1);
              end
            end
            skmm_pkg::CMD_QUERY: begin
              old_key_d   = key_in;
              new_key_d   = new_in;
              loc_d       = '0;
              found_d     = '0;
              step_d      = TOP_STEP;
              probe_d     = TOP_STEP;
              pend_d      = TOP_STEP < count_ext;
              key_re_o    = TOP_STEP < count_ext;
              key_raddr_o = TOP_STEP[IDX_W-1:0];
            end
            skmm_pkg::CMD_READ: begin
              if (idx_in_range) begin
                mark_re_o = 1'b1;
              end else begin
                res_d.status = skmm_pkg::STS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      skmm_pkg::S_SEARCH: begin
        loc_d = search_loc;
        if (step_q == ONE_STEP) begin
          // last step done: start the forward scan at the found location
          probe_d     = search_loc;
          pend_d      = search_loc < count_ext;
          key_re_o    = search_loc < count_ext;
          key_raddr_o = search_loc[IDX_W-1:0];
        end else begin
          step_d      = step_q >> 1;
          probe_d     = next_probe;
          pend_d      = next_probe < count_ext;
          key_re_o    = next_probe < count_ext;
          key_raddr_o = next_probe[IDX_W-1:0];
        end
      end
      skmm_pkg::S_SCAN: begin
        if (pend_q && !key_gt) begin
          if (key_eq) begin
            mark_we_o    = 1'b1;
            mark_waddr_o = probe_q[IDX_W-1:0];
            mark_wdata_o = {1'b1, new_key_q};
            found_d      = found_q + CNT_W'(1);
          end
          probe_d     = probe_q + PW'(1);
          pend_d      = (probe_q + PW'(1)) < count_ext;
          key_re_o    = (probe_q + PW'(1)) < count_ext;
          key_raddr_o = probe_d[IDX_W-1:0];
        end else begin
          res_d.status      = (found_q == '0) ? skmm_pkg::STS_NOMATCH : skmm_pkg::STS_OK;
          res_d.match_count = found_ext[skmm_pkg::MCOUNT_W-1:0];
        end
      end
      skmm_pkg::S_READ: begin
        res_d.replacement       = repl_ext[skmm_pkg::REPL_W-1:0];
        res_d.replacement_valid = mark_rdata_i[KW];
      end
      skmm_pkg::S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skmm_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_key_q <= old_key_d;
    new_key_q <= new_key_d;
    loc_q     <= loc_d;
    probe_q   <= probe_d;
    found_q   <= found_d;
    res_q     <= res_d;
  end

endmodule

FILE: hw/rtl/skmm_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skmm_out_buf
// Output register that holds one result until the master side takes it.
// ----------------------------------------------------------------------------
module skmm_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  skmm_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output skmm_pkg::result_t out_o
);

  logic              valid_q, valid_d;
  skmm_pkg::result_t data_q, data_d;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        data_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

FILE: hw/rtl/sorted_key_match_and_mark.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_match_and_mark
// Sorted key table with binary search, match marking and mark read-back.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (lsb first)                              tuser
//  s_axis    in   designation_key[55:0] new_designation[111:56]   command[1:0]
//                 entry_index[121:112], zero pad to 128
//  m_axis    out  status[1:0] match_count[12:2]                   -
//                 replacement[68:13] replacement_valid[69], pad to 72
//
//  one transaction at a time; s_axis_tready is high only while idle
//  load and unknown command pass from S_IDLE to S_RESP, read through S_READ if in range
//  query: S_SEARCH for each search step, then S_SCAN over the scanned entries, one key
//  memory read per cycle for each search step and each scanned entry
//  reset clears the entry count and control state, not the key and mark memories;
//  a mark is cleared as its key is loaded; a held result stalls nothing until the next result is ready
// ----------------------------------------------------------------------------
module sorted_key_match_and_mark #(
  parameter int unsigned TABLE_DEPTH = skmm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_CHARS   = skmm_pkg::KEY_CHARS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // designation_key, new_designation, entry_index, zero pad
  input  logic [127:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, match_count, replacement, replacement_valid, zero pad
  output logic [71:0]  m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KW    = 8 * KEY_CHARS;

  logic              res_valid, res_ready;
  skmm_pkg::result_t res, out_res;

  logic              key_we, key_re;
  logic [IDX_W-1:0]  key_waddr, key_raddr;
  logic [KW-1:0]     key_wdata, key_rdata;
  logic              mark_we, mark_re;
  logic [IDX_W-1:0]  mark_waddr, mark_raddr;
  logic [KW:0]       mark_wdata, mark_rdata;

  skmm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS  (KEY_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .key_i       (s_axis_tdata[55:0]),
    .new_key_i   (s_axis_tdata[111:56]),
    .idx_i       (s_axis_tdata[121:112]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .key_we_o    (key_we),
    .key_waddr_o (key_waddr),
    .key_wdata_o (key_wdata),
    .key_re_o    (key_re),
    .key_raddr_o (key_raddr),
    .key_rdata_i (key_rdata),
    .mark_we_o   (mark_we),
    .mark_waddr_o(mark_waddr),
    .mark_wdata_o(mark_wdata),
    .mark_re_o   (mark_re),
    .mark_raddr_o(mark_raddr),
    .mark_rdata_i(mark_rdata)
  );

  skmm_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KW)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  // mark word: valid flag above the new key
  skmm_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KW + 1)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .waddr_i(mark_waddr),
    .wdata_i(mark_wdata),
    .re_i   (mark_re),
    .raddr_i(mark_raddr),
    .rdata_o(mark_rdata)
  );

  skmm_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (out_res)
  );

  assign m_axis_tdata = {2'b00,
                         out_res.replacement_valid,
                         out_res.replacement,
                         out_res.match_count,
                         out_res.status};

endmodule

FILE: verif/sorted_key_match_and_mark_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_match_and_mark_checker
// Watches both stream channels of the key table, keeps its own copy of the
// keys and marks, works out the answer to every accepted command and
// compares each returned answer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module sorted_key_match_and_mark_checker
  import skmm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // designation_key, new_designation, entry_index, zero pad
  input  logic [127:0] s_tdata_i,
  // command
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // status, match_count, replacement, replacement_valid, zero pad
  input  logic [71:0]  m_tdata_i,
  output int           mismatch_count_o,
  output int           pending_o,
  output int           answers_o
);

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  logic [KEY_IN_W-1:0] key_table  [DEPTH];
  logic [REPL_W-1:0]   mark_table [DEPTH];
  logic                mark_set   [DEPTH];
  int unsigned         entries;
  result_t             due_answers_q[$];

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      key_table[i]  = '0;
      mark_table[i] = '0;
      mark_set[i]   = 1'b0;
    end
    entries          = 0;
    mismatch_count_o = 0;
    pending_o        = 0;
    answers_o        = 0;
  end

  // applies one command to the local table copy and returns its answer
  function automatic result_t apply_command(input logic [1:0]          cmd,
                                            input logic [KEY_IN_W-1:0] key,
                                            input logic [KEY_IN_W-1:0] mark,
                                            input logic [IDX_IN_W-1:0] idx);
    result_t     ans;
    int unsigned pos;
    int unsigned step;
    int unsigned probe;
    int unsigned hits;
    ans.status            = STS_OK;
    ans.match_count       = '0;
    ans.replacement       = '0;
    ans.replacement_valid = 1'b0;
    pos  = 0;
    hits = 0;
    step = 1;
    case (cmd)
      CMD_LOAD: begin
        if (entries >= DEPTH) begin
          ans.status = STS_FULL;
        end else begin
          key_table[entries] = key;
          entries++;
        end
      end
      CMD_QUERY: begin
        while (step * 2 <= DEPTH) step = step * 2;
        // power-of-two descent to the last entry below the old key
        for (; step != 0; step = step >> 1) begin
          probe = pos + step;
          if (probe < entries && key_table[probe] < key) pos = probe;
        end
        while (pos < entries && key_table[pos] <= key) begin
          if (key_table[pos] == key) begin
            mark_table[pos] = mark;
            mark_set[pos]   = 1'b1;
            hits++;
          end
          pos++;
        end
        if (hits == 0) ans.status = STS_NOMATCH;
        else ans.match_count = MCOUNT_W'(hits);
      end
      CMD_READ: begin
        if (idx >= entries) begin
          ans.status = STS_RANGE;
        end else begin
          ans.replacement       = mark_table[idx];
          ans.replacement_valid = mark_set[idx];
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        due_answers_q.push_back(apply_command(s_tuser_i, s_tdata_i[55:0],
                                              s_tdata_i[111:56], s_tdata_i[121:112]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status            = status_e'(m_tdata_i[1:0]);
        got.match_count       = m_tdata_i[12:2];
        got.replacement       = m_tdata_i[68:13];
        got.replacement_valid = m_tdata_i[69];
        answers_o++;
        if (due_answers_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("[%0t] unexpected answer: status %0d count %0d mark %h valid %b",
                     $realtime, got.status, got.match_count, got.replacement,
                     got.replacement_valid);
          end
          mismatch_count_o++;
        end else begin
          want = due_answers_q.pop_front();
          if (got.status !== want.status || got.match_count !== want.match_count ||
              got.replacement !== want.replacement ||
              got.replacement_valid !== want.replacement_valid) begin
            if (mismatch_count_o < 10) begin
              $display("[%0t] answer %0d mismatch:", $realtime, answers_o);
              $display("  expected status %0d count %0d mark %h valid %b",
                       want.status, want.match_count, want.replacement,
                       want.replacement_valid);
              $display("  actual   status %0d count %0d mark %h valid %b",
                       got.status, got.match_count, got.replacement,
                       got.replacement_valid);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_o = due_answers_q.size();
    end
  end

endmodule

FILE: verif/sorted_key_match_and_mark_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_match_and_mark_tb
// Drives load, query, read and unknown commands into the key table: a short
// directed opening, a long random mix of ascending loads with duplicates,
// stray unsorted loads, queries and reads, then a closing burst that also
// uses the extreme keys. Both stream sides stall at random; the checker module judges
// the answers.
// ----------------------------------------------------------------------------
module sorted_key_match_and_mark_tb;
  import skmm_pkg::*;

  localparam int unsigned         DEPTH        = TABLE_DEPTH_DEF;
  localparam logic [1:0]          CMD_UNKNOWN  = 2'd3;
  localparam logic [KEY_IN_W-1:0] KEY_MAX      = '1;
  localparam int unsigned         RANDOM_ITEMS = 560;
  localparam int unsigned         STALL_LIMIT  = 20000;
  localparam int unsigned         DRAIN_CYCLES = 40;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  bit                  steady;
  int                  n_loads, n_full, n_queries, n_reads, n_other, n_entries;
  int                  stall_cycles;
  int                  mismatches, pending, answers;
  logic [KEY_IN_W-1:0] loaded_keys_q[$];
  logic [KEY_IN_W-1:0] key_base;

  sorted_key_match_and_mark #(
    .TABLE_DEPTH(DEPTH),
    .KEY_CHARS  (KEY_CHARS_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  sorted_key_match_and_mark_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .answers_o       (answers)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, giving up", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [KEY_IN_W-1:0] random_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return KEY_MAX;
    return KEY_IN_W'({$urandom, $urandom});
  endfunction

  // ascending keys, often repeated so that queries hit several entries
  function automatic logic [KEY_IN_W-1:0] next_sorted_key(input bit fine_steps);
    int unsigned         r;
    logic [KEY_IN_W-1:0] inc;
    r = $urandom_range(0, 99);
    if (r < 40) inc = '0;
    else if (r < 80 || fine_steps) inc = KEY_IN_W'($urandom_range(1, 3));
    else inc = KEY_IN_W'($urandom_range(1, 65535)) << $urandom_range(0, 24);
    key_base = key_base + inc;
    return key_base;
  endfunction

  function automatic logic [KEY_IN_W-1:0] loaded_key();
    if (loaded_keys_q.size() == 0) return random_key();
    return loaded_keys_q[$urandom_range(0, loaded_keys_q.size() - 1)];
  endfunction

  function automatic logic [IDX_IN_W-1:0] stored_index();
    if (n_entries == 0) return IDX_IN_W'($urandom_range(0, 1023));
    return IDX_IN_W'($urandom_range(0, n_entries - 1));
  endfunction

  // called and returns at a falling edge; valid stays up for a back-to-back item
  task automatic drive_item(input logic [1:0]          cmd,
                            input logic [KEY_IN_W-1:0] key,
                            input logic [KEY_IN_W-1:0] mark,
                            input logic [IDX_IN_W-1:0] idx);
    while (!steady && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, idx, mark, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (cmd)
      CMD_LOAD: begin
        n_loads++;
        if (n_entries < DEPTH) begin
          n_entries++;
          loaded_keys_q.push_back(key);
        end else begin
          n_full++;
        end
      end
      CMD_QUERY: n_queries++;
      CMD_READ:  n_reads++;
      default:   n_other++;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sel;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    key_base      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, unknown command, duplicates, remarking and a zero mark
    drive_item(CMD_QUERY, '0, KEY_MAX, '0);
    drive_item(CMD_READ, KEY_MAX, KEY_MAX, '0);
    drive_item(CMD_READ, '0, '0, '1);
    drive_item(CMD_UNKNOWN, KEY_MAX, KEY_MAX, '1);
    drive_item(CMD_LOAD, '0, KEY_MAX, '1);
    drive_item(CMD_LOAD, '0, '0, '0);
    drive_item(CMD_LOAD, KEY_IN_W'(5), '0, '0);
    drive_item(CMD_QUERY, '0, KEY_MAX, '0);
    drive_item(CMD_READ, '0, '0, IDX_IN_W'(0));
    drive_item(CMD_READ, '0, '0, IDX_IN_W'(1));
    drive_item(CMD_READ, '0, '0, IDX_IN_W'(2));
    drive_item(CMD_READ, '0, '0, IDX_IN_W'(3));
    drive_item(CMD_QUERY, '0, KEY_IN_W'(56'h41_42_43_44_45_46_47), '0);
    drive_item(CMD_READ, KEY_MAX, KEY_MAX, IDX_IN_W'(0));
    drive_item(CMD_QUERY, KEY_IN_W'(3), random_key(), '0);
    drive_item(CMD_QUERY, KEY_MAX, random_key(), '1);
    drive_item(CMD_QUERY, KEY_IN_W'(5), '0, '0);
    drive_item(CMD_READ, '0, KEY_MAX, IDX_IN_W'(2));
    wait_drained();
    key_base = KEY_IN_W'(5);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 200 && i < 330);
      if (i == 400) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // mostly ascending loads, now and then a stray one out of order
        if ($urandom_range(0, 9) == 0) begin
          drive_item(CMD_LOAD, random_key(), random_key(), IDX_IN_W'($urandom));
        end else begin
          drive_item(CMD_LOAD, next_sorted_key(1'b0), random_key(), IDX_IN_W'($urandom));
        end
      end else if (sel < 75) begin
        if ($urandom_range(0, 4) != 0) begin
          drive_item(CMD_QUERY, loaded_key(), random_key(), IDX_IN_W'($urandom));
        end else begin
          drive_item(CMD_QUERY, random_key(), random_key(), IDX_IN_W'($urandom));
        end
      end else if (sel < 95) begin
        if ($urandom_range(0, 9) < 7) begin
          drive_item(CMD_READ, random_key(), random_key(), stored_index());
        end else begin
          drive_item(CMD_READ, random_key(), random_key(), IDX_IN_W'($urandom));
        end
      end else begin
        drive_item(CMD_UNKNOWN, random_key(), random_key(), IDX_IN_W'($urandom));
      end
    end
    steady = 1'b0;
    wait_drained();

    repeat (3) drive_item(CMD_LOAD, random_key(), random_key(), IDX_IN_W'($urandom));
    drive_item(CMD_QUERY, KEY_MAX, random_key(), IDX_IN_W'($urandom));
    drive_item(CMD_READ, '0, '0, IDX_IN_W'(DEPTH - 1));
    repeat (8) begin
      drive_item(CMD_QUERY, loaded_key(), random_key(), IDX_IN_W'($urandom));
      drive_item(CMD_READ, random_key(), random_key(), IDX_IN_W'($urandom));
    end
    drive_item(CMD_QUERY, '0, random_key(), '0);
    drive_item(CMD_QUERY, KEY_MAX, '0, '1);
    drive_item(CMD_READ, KEY_MAX, KEY_MAX, IDX_IN_W'(DEPTH - 1));
    drive_item(CMD_UNKNOWN, random_key(), random_key(), IDX_IN_W'($urandom));

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads (%0d entries, %0d refused on a full table), %0d queries,",
             n_loads, n_entries, n_full, n_queries);
    $display("%0d reads, %0d unknown commands; %0d answers checked, %0d mismatches",
             n_reads, n_other, answers, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
